// ===== src/i2cms_pkg.sv =====
// Package: shared types and constants for the I2C master transfer sequencer.
`default_nettype none

package i2cms_pkg;

    localparam int COUNT_BITS = 8;

    localparam logic [7:0] RETRY_LIMIT_RESET = 8'd3;
    localparam logic [7:0] RETRY_MAX         = 8'hFF;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_RXEN  = 3'd4,
        CMD_ACK   = 3'd5,
        CMD_NACK  = 3'd6
    } command_t;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_OK   = 2'd1,
        ST_FAIL = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [6:0] slave_address;
        logic       rw_bit;
        logic [7:0] length;
        logic [7:0] data_byte;
        logic       tx_done;
        logic       ack_received;
        logic [7:0] rx_byte;
    } tick_t;

    typedef struct packed {
        status_t    status;
        command_t   command;
        logic [7:0] tx_byte;
        logic [7:0] byte_index;
        logic       rx_valid;
        logic [7:0] received_byte;
        logic       done_event;
    } result_t;

endpackage

`default_nettype wire

// ===== src/i2c_master_transfer_sequencer.sv =====
// Top level: I2C master write/read transaction sequencer, one step per poll tick.
//
//  channel   dir  handshake                     payload
//  tick      in   tick_valid / tick_ready        tick (tick_t)
//  result    out  result_valid / result_ready    result (result_t)
//  limit     in   limit_wr_en                    limit_wr_data (8 bits)
//
// One tick per cycle while tick_ready is high; its result appears in the result register on the next cycle.
// The step logic sits between the tick port and the result register, one pass per tick.
// tick_ready drops only while a result is held and result_ready is low.
// Reset: retry limit 3, both machines at start, counters clear, status busy.
`default_nettype none

module i2c_master_transfer_sequencer
    import i2cms_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    tick_valid,
    output logic         tick_ready,
    input  wire tick_t   tick,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result,
    input  wire logic    limit_wr_en,
    input  wire logic [7:0] limit_wr_data
);

    typedef enum logic [3:0] {
        W_START    = 4'd0,
        W_ADDR     = 4'd1,
        W_CHK_ADDR = 4'd2,
        W_DATA     = 4'd3,
        W_CHK_DATA = 4'd4,
        W_CHK_LEN  = 4'd5,
        W_STOP     = 4'd6,
        W_DONE     = 4'd7,
        W_CHK_ACK  = 4'd8,
        W_ERROR    = 4'd9
    } wphase_t;

    typedef enum logic [1:0] {
        WR_START = 2'd0,
        WR_DATA  = 2'd1,
        WR_LEN   = 2'd2
    } wret_t;

    typedef enum logic [3:0] {
        R_START    = 4'd0,
        R_ADDR     = 4'd1,
        R_CHK_ADDR = 4'd2,
        R_CHK_ACK  = 4'd3,
        R_GET      = 4'd4,
        R_READ     = 4'd5,
        R_CHK_LEN  = 4'd6,
        R_STOP     = 4'd7,
        R_ERROR    = 4'd8
    } rphase_t;

    logic [7:0] limit_reg;
    wphase_t    wphase_reg, wphase_next;
    wret_t      wret_reg, wret_next;
    logic [7:0] wretries_reg, wretries_next;
    count_t     wremain_reg, wremain_next;
    count_t     windex_reg, windex_next;
    status_t    wstatus_reg, wstatus_next;
    rphase_t    rphase_reg, rphase_next;
    count_t     rcount_reg, rcount_next;
    logic [7:0] rretries_reg, rretries_next;
    count_t     rlength_reg, rlength_next;
    status_t    rstatus_reg, rstatus_next;
    logic       result_valid_reg;
    result_t    result_reg, result_next;

    logic       tick_xfer;
    logic [7:0] addr_byte;
    logic [7:0] wretries_bump;
    logic [7:0] rretries_bump;
    count_t     wremain_dec;

    assign tick_ready   = !result_valid_reg || result_ready;
    assign tick_xfer    = tick_valid && tick_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign addr_byte     = {tick.slave_address, tick.rw_bit};
    assign wretries_bump = (wretries_reg == RETRY_MAX) ? RETRY_MAX : wretries_reg + 8'd1;
    assign rretries_bump = (rretries_reg == RETRY_MAX) ? RETRY_MAX : rretries_reg + 8'd1;
    assign wremain_dec   = (wremain_reg != '0) ? wremain_reg - count_t'(1) : wremain_reg;

    always_comb
    begin
        wphase_next   = wphase_reg;
        wret_next     = wret_reg;
        wretries_next = wretries_reg;
        wremain_next  = wremain_reg;
        windex_next   = windex_reg;
        wstatus_next  = wstatus_reg;
        rphase_next   = rphase_reg;
        rcount_next   = rcount_reg;
        rretries_next = rretries_reg;
        rlength_next  = rlength_reg;
        rstatus_next  = rstatus_reg;

        result_next               = '0;
        result_next.command       = CMD_NONE;
        result_next.status        = ST_BUSY;

        unique case (tick.opcode)
            OP_WRITE:
            begin
                result_next.byte_index = 8'(windex_reg);
                unique case (wphase_reg)
                    W_START:
                    begin
                        result_next.command = CMD_START;
                        wstatus_next        = ST_BUSY;
                        wphase_next         = W_ADDR;
                    end
                    W_ADDR:
                    begin
                        result_next.command = CMD_WRITE;
                        result_next.tx_byte = addr_byte;
                        wremain_next        = count_t'(tick.length);
                        windex_next         = '0;
                        wphase_next         = W_CHK_ADDR;
                    end
                    W_CHK_ADDR:
                    begin
                        if (tick.tx_done)
                        begin
                            wret_next   = WR_DATA;
                            wphase_next = W_CHK_ACK;
                        end
                    end
                    W_DATA:
                    begin
                        result_next.command = CMD_WRITE;
                        result_next.tx_byte = tick.data_byte;
                        wphase_next         = W_CHK_DATA;
                    end
                    W_CHK_DATA:
                    begin
                        if (tick.tx_done)
                        begin
                            wret_next   = WR_LEN;
                            wphase_next = W_CHK_ACK;
                        end
                    end
                    W_CHK_LEN:
                    begin
                        if (wremain_reg != '0)
                        begin
                            windex_next = windex_reg + count_t'(1);
                        end
                        wremain_next = wremain_dec;
                        wphase_next  = (wremain_dec == '0) ? W_STOP : W_DATA;
                    end
                    W_STOP:
                    begin
                        result_next.command = CMD_STOP;
                        wphase_next         = W_DONE;
                    end
                    W_DONE:
                    begin
                        wphase_next  = W_START;
                        wret_next    = WR_START;
                        wstatus_next = ST_OK;
                    end
                    W_CHK_ACK:
                    begin
                        wretries_next = wretries_bump;
                        if (tick.ack_received)
                        begin
                            wretries_next = '0;
                            unique case (wret_reg)
                                WR_DATA: wphase_next = W_DATA;
                                WR_LEN:  wphase_next = W_CHK_LEN;
                                default: wphase_next = W_START;
                            endcase
                        end
                        else if (wretries_bump >= limit_reg)
                        begin
                            wphase_next = W_ERROR;
                        end
                    end
                    W_ERROR:
                    begin
                        wphase_next   = W_START;
                        wret_next     = WR_START;
                        wretries_next = '0;
                        wstatus_next  = ST_FAIL;
                    end
                    default:
                    begin
                        wphase_next = W_START;
                    end
                endcase
                result_next.status = wstatus_next;
            end
            OP_READ:
            begin
                result_next.byte_index = 8'(rcount_reg);
                unique case (rphase_reg)
                    R_START:
                    begin
                        result_next.command = CMD_START;
                        rstatus_next        = ST_BUSY;
                        rphase_next         = R_ADDR;
                    end
                    R_ADDR:
                    begin
                        result_next.command = CMD_WRITE;
                        result_next.tx_byte = addr_byte;
                        rlength_next        = count_t'(tick.length);
                        rphase_next         = R_CHK_ADDR;
                    end
                    R_CHK_ADDR:
                    begin
                        if (tick.tx_done)
                        begin
                            rphase_next = R_CHK_ACK;
                        end
                    end
                    R_CHK_ACK:
                    begin
                        rretries_next = rretries_bump;
                        if (tick.ack_received)
                        begin
                            rretries_next = '0;
                            rphase_next   = R_GET;
                        end
                        else if (rretries_bump >= limit_reg)
                        begin
                            rphase_next = R_ERROR;
                        end
                    end
                    R_GET:
                    begin
                        result_next.command = CMD_RXEN;
                        rphase_next         = R_READ;
                    end
                    R_READ:
                    begin
                        if (tick.tx_done)
                        begin
                            result_next.rx_valid      = 1'b1;
                            result_next.received_byte = tick.rx_byte;
                            rcount_next               = rcount_reg + count_t'(1);
                            rphase_next               = R_CHK_LEN;
                        end
                    end
                    R_CHK_LEN:
                    begin
                        if (rcount_reg >= rlength_reg)
                        begin
                            result_next.command = CMD_NACK;
                            rphase_next         = R_STOP;
                            rcount_next         = '0;
                        end
                        else
                        begin
                            result_next.command = CMD_ACK;
                            rphase_next         = R_GET;
                        end
                    end
                    R_STOP:
                    begin
                        result_next.command    = CMD_STOP;
                        result_next.done_event = 1'b1;
                        rstatus_next           = ST_OK;
                        rphase_next            = R_START;
                    end
                    R_ERROR:
                    begin
                        rphase_next   = R_START;
                        rretries_next = '0;
                        rstatus_next  = ST_FAIL;
                    end
                    default:
                    begin
                        rphase_next = R_START;
                    end
                endcase
                result_next.status = rstatus_next;
            end
            default:
            begin
                result_next.status = ST_BUSY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg        <= RETRY_LIMIT_RESET;
            wphase_reg       <= W_START;
            wret_reg         <= WR_START;
            wretries_reg     <= '0;
            wremain_reg      <= '0;
            windex_reg       <= '0;
            wstatus_reg      <= ST_BUSY;
            rphase_reg       <= R_START;
            rcount_reg       <= '0;
            rretries_reg     <= '0;
            rlength_reg      <= '0;
            rstatus_reg      <= ST_BUSY;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (limit_wr_en)
            begin
                limit_reg <= limit_wr_data;
            end
            if (tick_xfer)
            begin
                wphase_reg   <= wphase_next;
                wret_reg     <= wret_next;
                wretries_reg <= wretries_next;
                wremain_reg  <= wremain_next;
                windex_reg   <= windex_next;
                wstatus_reg  <= wstatus_next;
                rphase_reg   <= rphase_next;
                rcount_reg   <= rcount_next;
                rretries_reg <= rretries_next;
                rlength_reg  <= rlength_next;
                rstatus_reg  <= rstatus_next;
            end
            if (tick_xfer)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            result_reg <= result_next;
        end
    end

    // an accepted tick always leaves a result in the register
    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        tick_xfer |=> result_valid_reg)
        else $error("accepted tick produced no result");

    // a received byte comes only while the read machine waits, with no command
    a_rx_no_command: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.rx_valid) |->
            (result_reg.command == CMD_NONE && result_reg.status == ST_BUSY))
        else $error("rx_valid with a bus command or final status");

    // read completion comes with the stop and an ok status
    a_done_with_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.done_event) |->
            (result_reg.command == CMD_STOP && result_reg.status == ST_OK))
        else $error("done_event without stop and ok status");

    // only a write command carries a transmit byte
    a_tx_byte_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.command != CMD_WRITE) |->
            (result_reg.tx_byte == 8'd0))
        else $error("tx_byte set without a write command");

endmodule

`default_nettype wire
